// ===== hdl/rtcs_pkg.sv =====
// Types, constants and the overlap test shared by the rectangle table search.
package rtcs_pkg;

	localparam int MAX_RECTS     = 64;
	localparam int IDX_W         = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
	localparam int CNT_W         = $clog2(MAX_RECTS + 1);
	localparam int HIT_INDEX_W   = 6;
	localparam int ENTRY_COUNT_W = 7;
	localparam int CMP_W         = (CNT_W > HIT_INDEX_W) ? CNT_W : HIT_INDEX_W;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [14:0]        w;
		logic [14:0]        h;
	} rect_t;

	localparam rect_t RESET_RECT = '{x: 16'sd100, y: 16'sd300, w: 15'd350, h: 15'd200};

	typedef enum logic [1:0] {
		ACT_APPEND = 2'd0,
		ACT_DELETE = 2'd1,
		ACT_QUERY  = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_FULL      = 2'd1,
		STS_BAD_INDEX = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_QUERY,
		S_DELETE,
		S_EMIT
	} state_t;

	function automatic logic collides(rect_t r, rect_t m);
		logic signed [16:0] rx, rr, ry, rb, mx, mr, my, mb;
		logic xc, yc;
		rx = 17'(r.x);
		ry = 17'(r.y);
		mx = 17'(m.x);
		my = 17'(m.y);
		rr = rx + $signed({2'b00, r.w});
		rb = ry + $signed({2'b00, r.h});
		mr = mx + $signed({2'b00, m.w});
		mb = my + $signed({2'b00, m.h});
		xc = ((rr < mr) && (rr > mx)) || ((rx > mx) && (rx < mr));
		yc = ((ry < mb) && (ry > my)) || ((rb < mb) && (rb > my));
		return xc && yc;
	endfunction

endpackage

// ===== hdl/rtcs_cmd_if.sv =====
// Command channel: one table action per transaction.
interface rtcs_cmd_if;
	logic               valid;
	logic               ready;
	logic [1:0]         action;
	logic signed [15:0] rect_x;
	logic signed [15:0] rect_y;
	logic [14:0]        rect_w;
	logic [14:0]        rect_h;
	logic [5:0]         entry_index;

	modport source (
		output valid, action, rect_x, rect_y, rect_w, rect_h, entry_index,
		input  ready
	);
	modport sink (
		input  valid, action, rect_x, rect_y, rect_w, rect_h, entry_index,
		output ready
	);
endinterface

// ===== hdl/rtcs_rsp_if.sv =====
// Response channel: one result per transaction.
interface rtcs_rsp_if;
	logic       valid;
	logic       ready;
	logic       hit;
	logic [5:0] hit_index;
	logic [1:0] status;
	logic [6:0] entry_count;

	modport source (
		output valid, hit, hit_index, status, entry_count,
		input  ready
	);
	modport sink (
		input  valid, hit, hit_index, status, entry_count,
		output ready
	);
endinterface

// ===== hdl/rect_table_collision_search.sv =====
// Rectangle table with append, ordered delete and first-hit collision query.
// Append, rejected delete, empty query and unused codes need no table scan: their result goes straight to emit.
// Query scans one entry per cycle from the table memory until the first hit or the last entry.
// Delete moves one entry per cycle through the memory port, shifting the entries above the index down by one.
// A new command is taken once the previous result sits in the output register.
// Reset: table holds one entry {100,300,350,200}, count 1; no clearing pass.
module rect_table_collision_search (
	input  logic       clk,
	input  logic       arst_n,
	rtcs_cmd_if.sink   cmd,
	rtcs_rsp_if.source rsp
);
	import rtcs_pkg::*;

	rect_t mem [MAX_RECTS];

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic [CNT_W-1:0]   ptr_q, ptr_d;
	logic               e0_wr_q;
	rect_t              query_q;

	logic               rd_en;
	logic [IDX_W-1:0]   rd_addr;
	logic               rd_vld_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic               rd_zero_s1;
	rect_t              mem_rd_s1;
	rect_t              rd_rect;

	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	rect_t              wr_data;

	logic               res_ld;
	logic               res_hit_d, res_hit_q;
	logic [IDX_W-1:0]   res_index_d, res_index_q;
	status_t            res_status_d, res_status_q;

	logic               out_ld;
	logic               rsp_valid_q;
	logic               rsp_hit_q;
	logic [5:0]         rsp_hit_index_q;
	logic [1:0]         rsp_status_q;
	logic [6:0]         rsp_count_q;

	logic               accept;
	rect_t              cmd_rect;
	logic               hit_now;
	logic               last_s1;

	assign cmd.ready = (state_q == S_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign cmd_rect  = '{x: cmd.rect_x, y: cmd.rect_y, w: cmd.rect_w, h: cmd.rect_h};
	assign rd_rect   = rd_zero_s1 ? RESET_RECT : mem_rd_s1;
	assign hit_now   = rd_vld_s1 && collides(query_q, rd_rect);
	assign last_s1   = (CNT_W'(idx_s1) + CNT_W'(1)) == count_q;

	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		ptr_d        = ptr_q;
		rd_en        = 1'b0;
		rd_addr      = ptr_q[IDX_W-1:0];
		wr_en        = 1'b0;
		wr_addr      = count_q[IDX_W-1:0];
		wr_data      = cmd_rect;
		res_ld       = 1'b0;
		res_hit_d    = 1'b0;
		res_index_d  = '0;
		res_status_d = STS_OK;
		out_ld       = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (action_t'(cmd.action))
						ACT_APPEND: begin
							res_ld  = 1'b1;
							state_d = S_EMIT;
							if (count_q >= CNT_W'(MAX_RECTS)) begin
								res_status_d = STS_FULL;
							end else begin
								wr_en   = 1'b1;
								count_d = count_q + CNT_W'(1);
							end
						end
						ACT_DELETE: begin
							if (CMP_W'(cmd.entry_index) >= CMP_W'(count_q)) begin
								res_ld       = 1'b1;
								res_status_d = STS_BAD_INDEX;
								state_d      = S_EMIT;
							end else begin
								ptr_d   = CNT_W'(cmd.entry_index) + CNT_W'(1);
								state_d = S_DELETE;
							end
						end
						ACT_QUERY: begin
							if (count_q == '0) begin
								res_ld  = 1'b1;
								state_d = S_EMIT;
							end else begin
								ptr_d   = '0;
								state_d = S_QUERY;
							end
						end
						default: begin
							res_ld  = 1'b1;
							state_d = S_EMIT;
						end
					endcase
				end
			end
			S_QUERY: begin
				priority if (hit_now) begin
					res_ld      = 1'b1;
					res_hit_d   = 1'b1;
					res_index_d = idx_s1;
					state_d     = S_EMIT;
				end else if (rd_vld_s1 && last_s1) begin
					res_ld  = 1'b1;
					state_d = S_EMIT;
				end else if (ptr_q < count_q) begin
					rd_en = 1'b1;
					ptr_d = ptr_q + CNT_W'(1);
				end
			end
			S_DELETE: begin
				if (rd_vld_s1) begin
					wr_en   = 1'b1;
					wr_addr = idx_s1 - IDX_W'(1);
					wr_data = rd_rect;
				end
				if (ptr_q < count_q) begin
					rd_en = 1'b1;
					ptr_d = ptr_q + CNT_W'(1);
				end else begin
					count_d = count_q - CNT_W'(1);
					res_ld  = 1'b1;
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (!rsp_valid_q || rsp.ready) begin
					out_ld  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= CNT_W'(1);
			ptr_q     <= '0;
			e0_wr_q   <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			ptr_q     <= ptr_d;
			rd_vld_s1 <= rd_en;
			if (wr_en && (wr_addr == '0)) begin
				e0_wr_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_rd_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			idx_s1     <= rd_addr;
			rd_zero_s1 <= (rd_addr == '0) && !e0_wr_q;
		end
		if (accept) begin
			query_q <= cmd_rect;
		end
		if (res_ld) begin
			res_hit_q    <= res_hit_d;
			res_index_q  <= res_index_d;
			res_status_q <= res_status_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_ld) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			rsp_hit_q       <= res_hit_q;
			rsp_hit_index_q <= HIT_INDEX_W'(res_index_q);
			rsp_status_q    <= res_status_q;
			rsp_count_q     <= ENTRY_COUNT_W'(count_q);
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.hit         = rsp_hit_q;
	assign rsp.hit_index   = rsp_hit_index_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.entry_count = rsp_count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_RECTS))
		else $error("entry count above table size");

	a_shift_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DELETE && wr_en) |-> (CNT_W'(wr_addr) + CNT_W'(1) < count_q))
		else $error("delete shift writes outside the table");

	a_idle_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !rd_vld_s1)
		else $error("memory read in flight while idle");

	a_hit_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(res_ld && res_hit_d) |=> (CNT_W'(res_index_q) < count_q))
		else $error("hit index beyond entry count");

	a_emit_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_ld |=> (state_q == S_EMIT))
		else $error("result loaded without moving to emit");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the rectangle table: append, ordered delete and first-hit query.
module testbench;
	import rtcs_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int MODE_FILL   = 0;
	localparam int MODE_DRAIN  = 1;
	localparam int MODE_MIXED  = 2;
	localparam int PHASE_ITEMS = 217;
	localparam int SETTLE_CYCLES = 100;

	typedef struct {
		logic [1:0] action;
		rect_t      r;
		logic [5:0] entry_index;
	} table_cmd_t;

	typedef struct packed {
		logic       hit;
		logic [5:0] hit_index;
		logic [1:0] status;
		logic [6:0] entry_count;
	} table_result_t;

	class rect_table_tracker;
		rect_t         entries [MAX_RECTS];
		int            count;
		table_result_t awaited_results [$];
		int            errors;
		int            n_results, n_appends, n_full, n_deletes, n_bad, n_queries, n_hits, n_unused;

		function new();
			entries[0] = RESET_RECT;
			count = 1;
		endfunction

		function bit overlaps(rect_t q, rect_t m);
			int qx, qy, qr, qb, mx, my, mr, mb;
			bit xc, yc;
			qx = $signed(q.x);
			qy = $signed(q.y);
			mx = $signed(m.x);
			my = $signed(m.y);
			qr = qx + int'(q.w);
			qb = qy + int'(q.h);
			mr = mx + int'(m.w);
			mb = my + int'(m.h);
			xc = ((qr < mr) && (qr > mx)) || ((qx > mx) && (qx < mr));
			yc = ((qy < mb) && (qy > my)) || ((qb < mb) && (qb > my));
			return xc && yc;
		endfunction

		function void note_command(table_cmd_t c);
			table_result_t res;
			res = '0;
			case (c.action)
			ACT_APPEND: begin
				n_appends++;
				if (count >= MAX_RECTS) begin
					res.status = STS_FULL;
					n_full++;
				end else begin
					entries[count] = c.r;
					count++;
				end
			end
			ACT_DELETE: begin
				n_deletes++;
				if (int'(c.entry_index) >= count) begin
					res.status = STS_BAD_INDEX;
					n_bad++;
				end else begin
					for (int i = c.entry_index; i + 1 < count; i++)
						entries[i] = entries[i + 1];
					count--;
				end
			end
			ACT_QUERY: begin
				n_queries++;
				for (int i = 0; i < count; i++) begin
					if (overlaps(c.r, entries[i])) begin
						res.hit = 1'b1;
						res.hit_index = 6'(i);
						n_hits++;
						break;
					end
				end
			end
			default: n_unused++;
			endcase
			res.entry_count = 7'(count);
			awaited_results.push_back(res);
		endfunction

		function void compare_field(string name, logic [6:0] want, logic [6:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			end
		endfunction

		function void check_result(table_result_t got);
			table_result_t want;
			if (awaited_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, got hit=%0d idx=%0d sts=%0d cnt=%0d",
					$time, got.hit, got.hit_index, got.status, got.entry_count);
				return;
			end
			want = awaited_results.pop_front();
			n_results++;
			compare_field("hit", 7'(want.hit), 7'(got.hit));
			compare_field("hit_index", 7'(want.hit_index), 7'(got.hit_index));
			compare_field("status", 7'(want.status), 7'(got.status));
			compare_field("entry_count", want.entry_count, got.entry_count);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   src_idle_pct;
	int   sink_idle_pct;
	rect_table_tracker tracker;

	rtcs_cmd_if cmd_ch ();
	rtcs_rsp_if rsp_ch ();

	rect_table_collision_search dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_ch.ready = ($urandom_range(0, 99) >= sink_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			tracker.check_result('{hit: rsp_ch.hit, hit_index: rsp_ch.hit_index,
				status: rsp_ch.status, entry_count: rsp_ch.entry_count});
	end

	function automatic rect_t any_rect();
		rect_t r;
		r.x = 16'($urandom);
		r.y = 16'($urandom);
		r.w = 15'($urandom);
		r.h = 15'($urandom);
		return r;
	endfunction

	function automatic rect_t local_rect();
		rect_t r;
		r.x = 16'(int'($urandom_range(0, 4000)) - 2000);
		r.y = 16'(int'($urandom_range(0, 4000)) - 2000);
		r.w = 15'($urandom_range(0, 3000));
		r.h = 15'($urandom_range(0, 3000));
		return r;
	endfunction

	function automatic rect_t probe_near(rect_t m);
		rect_t r;
		int sx, sy;
		sx = int'(m.w) + 2;
		sy = int'(m.h) + 2;
		r.x = 16'($signed(m.x) - sx / 4 + int'($urandom_range(0, sx)));
		r.y = 16'($signed(m.y) - sy / 4 + int'($urandom_range(0, sy)));
		r.w = 15'($urandom_range(0, sx / 2));
		r.h = 15'($urandom_range(0, sy / 2));
		return r;
	endfunction

	function automatic table_cmd_t make_cmd(logic [1:0] action, rect_t r, logic [5:0] entry_index);
		table_cmd_t c;
		c.action = action;
		c.r = r;
		c.entry_index = entry_index;
		return c;
	endfunction

	function automatic table_cmd_t next_random_cmd(int mode);
		table_cmd_t c;
		int roll, pick;
		roll = $urandom_range(0, 99);
		pick = $urandom_range(0, 99);
		c.r = any_rect();
		c.entry_index = 6'($urandom);
		case (mode)
		MODE_FILL:  c.action = (roll < 90) ? ACT_APPEND : ACT_QUERY;
		MODE_DRAIN: c.action = (roll < 80) ? ACT_DELETE : ACT_QUERY;
		default: begin
			if (roll < 45)
				c.action = ACT_QUERY;
			else if (roll < 70)
				c.action = ACT_APPEND;
			else if (roll < 95)
				c.action = ACT_DELETE;
			else
				c.action = ACT_UNUSED;
		end
		endcase
		if (c.action == ACT_APPEND && pick < 75)
			c.r = local_rect();
		if (c.action == ACT_DELETE && tracker.count > 0 && pick < 85)
			c.entry_index = 6'($urandom_range(0, tracker.count - 1));
		if (c.action == ACT_QUERY) begin
			if (tracker.count > 0 && pick < 70)
				c.r = probe_near(tracker.entries[$urandom_range(0, tracker.count - 1)]);
			else if (pick < 85)
				c.r = local_rect();
		end
		return c;
	endfunction

	task automatic send_command(input table_cmd_t c);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			cmd_ch.valid = 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid       = 1'b1;
		cmd_ch.action      = c.action;
		cmd_ch.rect_x      = c.r.x;
		cmd_ch.rect_y      = c.r.y;
		cmd_ch.rect_w      = c.r.w;
		cmd_ch.rect_h      = c.r.h;
		cmd_ch.entry_index = c.entry_index;
		do @(posedge clk); while (!cmd_ch.ready);
		tracker.note_command(c);
		@(negedge clk);
	endtask

	initial begin
		table_cmd_t c;
		int mode, len, done, roll;
		tracker = new();
		src_idle_pct  = 31;
		sink_idle_pct = 66;
		cmd_ch.valid       = 1'b0;
		cmd_ch.action      = ACT_APPEND;
		cmd_ch.rect_x      = '0;
		cmd_ch.rect_y      = '0;
		cmd_ch.rect_w      = '0;
		cmd_ch.rect_h      = '0;
		cmd_ch.entry_index = '0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_command(make_cmd(ACT_QUERY, '{x: 200, y: 350, w: 10, h: 10}, 0));
		send_command(make_cmd(ACT_QUERY, '{x: -32768, y: -32768, w: 0, h: 0}, 0));
		send_command(make_cmd(ACT_QUERY, '{x: 32767, y: 32767, w: 32767, h: 32767}, 63));
		send_command(make_cmd(ACT_APPEND, '{x: -32768, y: -32768, w: 32767, h: 32767}, 0));
		send_command(make_cmd(ACT_APPEND, '{x: 32767, y: 32767, w: 0, h: 0}, 0));
		send_command(make_cmd(ACT_APPEND, '{x: 0, y: 0, w: 0, h: 0}, 0));
		send_command(make_cmd(ACT_QUERY, '{x: -100, y: -100, w: 5, h: 5}, 0));
		send_command(make_cmd(ACT_QUERY, '{x: 99, y: 299, w: 352, h: 202}, 0));
		send_command(make_cmd(ACT_DELETE, '{x: 0, y: 0, w: 0, h: 0}, 63));
		send_command(make_cmd(ACT_DELETE, '{x: 0, y: 0, w: 0, h: 0}, 4));
		send_command(make_cmd(ACT_UNUSED, any_rect(), 6'($urandom)));
		send_command(make_cmd(ACT_DELETE, '{x: 0, y: 0, w: 0, h: 0}, 0));
		send_command(make_cmd(ACT_QUERY, '{x: -100, y: -100, w: 5, h: 5}, 0));
		send_command(make_cmd(ACT_DELETE, '{x: 0, y: 0, w: 0, h: 0}, 2));
		send_command(make_cmd(ACT_DELETE, '{x: 0, y: 0, w: 0, h: 0}, 0));
		send_command(make_cmd(ACT_DELETE, '{x: 0, y: 0, w: 0, h: 0}, 0));
		send_command(make_cmd(ACT_DELETE, '{x: 0, y: 0, w: 0, h: 0}, 0));
		send_command(make_cmd(ACT_QUERY, '{x: 200, y: 350, w: 10, h: 10}, 0));
		send_command(make_cmd(ACT_APPEND, '{x: 100, y: 300, w: 350, h: 200}, 0));
		send_command(make_cmd(ACT_QUERY, '{x: 449, y: 499, w: 5, h: 5}, 0));

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
			0: begin
				src_idle_pct  = 31;
				sink_idle_pct = 66;
			end
			1: begin
				src_idle_pct  = 66;
				sink_idle_pct = 31;
			end
			default: begin
				src_idle_pct  = 0;
				sink_idle_pct = 0;
			end
			endcase
			done = 0;
			mode = MODE_FILL;
			while (done < PHASE_ITEMS) begin
				case (mode)
				MODE_FILL:  len = MAX_RECTS - tracker.count + $urandom_range(2, 5);
				MODE_DRAIN: len = tracker.count + $urandom_range(1, 4);
				default:    len = $urandom_range(10, 30);
				endcase
				for (int k = 0; k < len && done < PHASE_ITEMS; k++) begin
					c = next_random_cmd(mode);
					send_command(c);
					if (c.action != ACT_UNUSED)
						done++;
				end
				roll = $urandom_range(0, 99);
				mode = (roll < 20) ? MODE_FILL : (roll < 40) ? MODE_DRAIN : MODE_MIXED;
			end
		end
		cmd_ch.valid = 1'b0;

		while (tracker.awaited_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Checked %0d results: %0d appends (%0d refused as full), %0d deletes (%0d bad index),",
			tracker.n_results, tracker.n_appends, tracker.n_full, tracker.n_deletes, tracker.n_bad);
		$display("%0d queries (%0d hits), %0d unused codes, %0d mismatches.",
			tracker.n_queries, tracker.n_hits, tracker.n_unused, tracker.errors);
		if (tracker.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
